### rtl/lcadc_pkg.sv
// Shared constants and types of the load-cell converter reader.
`default_nettype none
package lcadc_pkg;

    localparam int SAMPLE_BITS_DEF = 24;
    localparam int SUM_W           = 32;
    localparam int NET_W           = 25;
    localparam int OFF_W           = 24;
    localparam int CNT_W           = 8;
    localparam int DEN_W           = CNT_W + 1;
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 24;

    localparam logic signed [NET_W-1:0] NET_MAX = NET_W'(16777215);
    localparam logic signed [NET_W-1:0] NET_MIN = NET_W'(-16777215);

    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_PULSES   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_AVERAGE_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET        = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_POWER_DOWN    = 2'd3;

    typedef struct packed {
        logic [1:0]       gain_pulses;
        logic [CNT_W-1:0] average_count;
        logic [OFF_W-1:0] offset;
        logic             power_down;
    } t_cfg;

    typedef struct packed {
        logic sck;
        logic busy;
        logic sample_valid;
        logic div_start;
    } t_step_flags;

endpackage
`default_nettype wire

### rtl/lcadc_seq.sv
// Tick sequencer: serial clock phases, bit shifting and reading accumulation.
`default_nettype none
module lcadc_seq #(
    parameter int SAMPLE_BITS = lcadc_pkg::SAMPLE_BITS_DEF
) (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   i_step,
    input  wire                                   i_action,
    input  wire                                   i_dout,
    input  wire lcadc_pkg::t_cfg                  i_cfg,
    output lcadc_pkg::t_step_flags                o_flags,
    output logic        [SAMPLE_BITS-1:0]         o_raw,
    output logic signed [lcadc_pkg::SUM_W-1:0]    o_div_sum,
    output logic        [lcadc_pkg::DEN_W-1:0]    o_div_den
);

    localparam int BC_W = $clog2(SAMPLE_BITS + 1);

    typedef enum logic [5:0] {
        PH_IDLE  = 6'b000001,
        PH_WAIT  = 6'b000010,
        PH_DHIGH = 6'b000100,
        PH_DLOW  = 6'b001000,
        PH_PHIGH = 6'b010000,
        PH_PLOW  = 6'b100000
    } t_phase;

    t_phase                                r_phase, n_phase;
    logic [BC_W-1:0]                       r_bit, n_bit;
    logic [SAMPLE_BITS-1:0]                r_shift, n_shift;
    logic [1:0]                            r_pulse, n_pulse;
    logic [lcadc_pkg::SUM_W-1:0]           r_sum, n_sum;
    logic [lcadc_pkg::CNT_W-1:0]           r_rd, n_rd;
    logic [SAMPLE_BITS-1:0]                r_last, n_last;

    logic [lcadc_pkg::SUM_W-1:0]           w_sum_add;
    logic [lcadc_pkg::CNT_W-1:0]           w_rd_inc;
    logic [1:0]                            w_need_p;
    logic [lcadc_pkg::CNT_W-1:0]           w_need_n;

    assign w_sum_add = r_sum + lcadc_pkg::SUM_W'($signed(r_shift));
    assign w_rd_inc  = r_rd + lcadc_pkg::CNT_W'(1);
    assign w_need_p  = (i_cfg.gain_pulses == 2'd0) ? 2'd1 : i_cfg.gain_pulses;
    assign w_need_n  = (i_cfg.average_count == '0) ? lcadc_pkg::CNT_W'(1)
                                                    : i_cfg.average_count;

    assign o_div_sum = $signed(w_sum_add);
    assign o_div_den = {(w_rd_inc == '0), w_rd_inc};
    assign o_raw     = n_last;

    always_comb begin
        n_phase = r_phase;
        n_bit   = r_bit;
        n_shift = r_shift;
        n_pulse = r_pulse;
        n_sum   = r_sum;
        n_rd    = r_rd;
        n_last  = r_last;
        o_flags = '0;
        if (i_cfg.power_down) begin
            n_phase = PH_IDLE;
            n_bit   = '0;
            n_shift = '0;
            n_pulse = '0;
            n_sum   = '0;
            n_rd    = '0;
            o_flags.sck = 1'b1;
        end else begin
            case (r_phase)
                PH_IDLE: begin
                    if (i_action) begin
                        n_phase = PH_WAIT;
                        n_bit   = '0;
                        n_shift = '0;
                        n_pulse = '0;
                        n_sum   = '0;
                        n_rd    = '0;
                    end
                end
                PH_WAIT: begin
                    if (!i_dout) begin
                        n_bit   = '0;
                        n_shift = '0;
                        n_pulse = '0;
                        n_phase = PH_DHIGH;
                    end
                end
                PH_DHIGH: begin
                    o_flags.sck = 1'b1;
                    n_shift = {r_shift[SAMPLE_BITS-2:0], i_dout};
                    n_bit   = r_bit + BC_W'(1);
                    n_phase = PH_DLOW;
                end
                PH_DLOW: begin
                    if (r_bit >= BC_W'(SAMPLE_BITS)) begin
                        n_pulse = '0;
                        n_phase = PH_PHIGH;
                    end else begin
                        n_phase = PH_DHIGH;
                    end
                end
                PH_PHIGH: begin
                    o_flags.sck = 1'b1;
                    n_pulse = r_pulse + 2'd1;
                    n_phase = PH_PLOW;
                end
                PH_PLOW: begin
                    if (r_pulse < w_need_p) begin
                        n_phase = PH_PHIGH;
                    end else begin
                        n_last = r_shift;
                        o_flags.sample_valid = 1'b1;
                        if ((w_rd_inc >= w_need_n) || (w_rd_inc == '0)) begin
                            o_flags.div_start = 1'b1;
                            n_phase = PH_IDLE;
                            n_bit   = '0;
                            n_shift = '0;
                            n_pulse = '0;
                            n_sum   = '0;
                            n_rd    = '0;
                        end else begin
                            n_sum   = w_sum_add;
                            n_rd    = w_rd_inc;
                            n_phase = PH_WAIT;
                        end
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                    n_bit   = '0;
                    n_shift = '0;
                    n_pulse = '0;
                    n_sum   = '0;
                    n_rd    = '0;
                end
            endcase
        end
        o_flags.busy = (n_phase != PH_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_bit   <= '0;
            r_shift <= '0;
            r_pulse <= '0;
            r_sum   <= '0;
            r_rd    <= '0;
            r_last  <= '0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_bit   <= n_bit;
            r_shift <= n_shift;
            r_pulse <= n_pulse;
            r_sum   <= n_sum;
            r_rd    <= n_rd;
            r_last  <= n_last;
        end
    end

endmodule
`default_nettype wire

### rtl/lcadc_div.sv
// Bit-serial signed divider with tare subtraction and saturation.
`default_nettype none
module lcadc_div (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   i_start,
    input  wire signed [lcadc_pkg::SUM_W-1:0]     i_sum,
    input  wire        [lcadc_pkg::DEN_W-1:0]     i_den,
    input  wire        [lcadc_pkg::OFF_W-1:0]     i_offset,
    output logic                                  o_done,
    output logic signed [lcadc_pkg::NET_W-1:0]    o_net
);

    localparam int SW   = lcadc_pkg::SUM_W;
    localparam int DW   = lcadc_pkg::DEN_W;
    localparam int QW   = SW + 2;
    localparam int CTRW = $clog2(SW + 1);

    typedef enum logic [3:0] {
        D_IDLE = 4'b0001,
        D_RUN  = 4'b0010,
        D_SIGN = 4'b0100,
        D_SUB  = 4'b1000
    } t_div_state;

    t_div_state                   r_state;
    logic [CTRW-1:0]              r_cnt;
    logic [SW-1:0]                r_mag;
    logic [DW-1:0]                r_rem;
    logic [DW-1:0]                r_den;
    logic                         r_neg;
    logic [lcadc_pkg::OFF_W-1:0]  r_off;
    logic signed [QW-1:0]         r_quo;
    logic                         r_done;
    logic signed [lcadc_pkg::NET_W-1:0] r_net;

    logic [DW:0]                  w_rem_sh;
    logic                         w_ge;
    logic [DW:0]                  w_rem_sub;
    logic signed [QW-1:0]         w_diff;

    assign w_rem_sh  = {r_rem, r_mag[SW-1]};
    assign w_ge      = (w_rem_sh >= {1'b0, r_den});
    assign w_rem_sub = w_rem_sh - {1'b0, r_den};
    assign w_diff    = r_quo - QW'($signed(r_off));

    assign o_done = r_done;
    assign o_net  = r_net;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
            r_cnt   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                D_IDLE: begin
                    if (i_start) begin
                        r_state <= D_RUN;
                        r_cnt   <= '0;
                    end
                end
                D_RUN: begin
                    r_cnt <= r_cnt + CTRW'(1);
                    if (r_cnt == CTRW'(SW - 1)) begin
                        r_state <= D_SIGN;
                    end
                end
                D_SIGN: begin
                    r_state <= D_SUB;
                end
                D_SUB: begin
                    r_state <= D_IDLE;
                    r_done  <= 1'b1;
                end
                default: begin
                    r_state <= D_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == D_IDLE) && i_start) begin
            r_neg <= i_sum[SW-1];
            r_mag <= i_sum[SW-1] ? SW'(-i_sum) : SW'(i_sum);
            r_rem <= '0;
            r_den <= i_den;
            r_off <= i_offset;
        end else if (r_state == D_RUN) begin
            r_rem <= w_ge ? w_rem_sub[DW-1:0] : w_rem_sh[DW-1:0];
            r_mag <= {r_mag[SW-2:0], w_ge};
        end
        if (r_state == D_SIGN) begin
            r_quo <= r_neg ? -$signed({2'b00, r_mag}) : $signed({2'b00, r_mag});
        end
        if (r_state == D_SUB) begin
            if (w_diff > QW'(lcadc_pkg::NET_MAX)) begin
                r_net <= lcadc_pkg::NET_MAX;
            end else if (w_diff < QW'(lcadc_pkg::NET_MIN)) begin
                r_net <= lcadc_pkg::NET_MIN;
            end else begin
                r_net <= w_diff[lcadc_pkg::NET_W-1:0];
            end
        end
    end

endmodule
`default_nettype wire

### rtl/load_cell_adc_serial_reader_core.sv
// Top level of the load-cell converter reader: handshakes, registers, output stage.
//
// Usage: each item on the slave stream is one half-period tick of the converter
// clock. tdata bit 0 carries the sampled data-pin level, tuser bit 0 a start
// request. Every accepted item yields exactly one item on the master stream with
// the clock level to drive, the busy flag, the last conversion word and, on the
// tick that ends a measurement, the averaged net value.
// Registers are written over the cfg channel (index 0 gain pulses, 1 average
// count, 2 offset, 3 power down), which is always ready.
// An ordinary tick is registered and appears at the output in the cycle after acceptance.
// The tick that ends a measurement runs the bit-serial divider: one quotient
// bit per cycle over the 32-bit sum, then one sign and one tare step; its
// result passes the divider's done register and then the output register.
// The block takes one item at a time; it takes the next item in the cycle its
// result leaves or while the output register is empty.
// A stalled receiver holds the output register and blocks further items.
// Reset clears the sequencer, the divider state and the output valid flag, and loads the
// register defaults: one gain pulse, average count one, zero offset, powered up.
`default_nettype none
module load_cell_adc_serial_reader_core #(
    parameter int SAMPLE_BITS = lcadc_pkg::SAMPLE_BITS_DEF
) (
    input  wire                                    i_clk,
    input  wire                                    i_rst_n,
    input  wire                                    s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  wire  [7:0]                             s_axis_tdata,  // dout
    input  wire  [0:0]                             s_axis_tuser,  // action
    output logic                                   m_axis_tvalid,
    input  wire                                    m_axis_tready,
    // sck, busy_res, raw_sample, net_value
    output logic [((SAMPLE_BITS + lcadc_pkg::NET_W + 2 + 7) / 8) * 8 - 1:0] m_axis_tdata,
    output logic [1:0]                             m_axis_tuser,  // sample_valid, done_res
    input  wire                                    i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire  [lcadc_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  wire  [lcadc_pkg::CFG_DATA_W-1:0]       i_cfg_data
);

    localparam int OUT_W = ((SAMPLE_BITS + lcadc_pkg::NET_W + 2 + 7) / 8) * 8;

    typedef enum logic [1:0] {
        T_IDLE = 2'b01,
        T_DIV  = 2'b10
    } t_top_state;

    t_top_state                           r_state;
    lcadc_pkg::t_cfg                      r_cfg;
    logic                                 r_m_valid;
    logic                                 r_sck;
    logic                                 r_busy;
    logic                                 r_sv;
    logic                                 r_done;
    logic [SAMPLE_BITS-1:0]               r_raw;
    logic signed [lcadc_pkg::NET_W-1:0]   r_net;

    logic                                 w_accept;
    lcadc_pkg::t_step_flags               w_flags;
    logic [SAMPLE_BITS-1:0]               w_raw;
    logic signed [lcadc_pkg::SUM_W-1:0]   w_div_sum;
    logic [lcadc_pkg::DEN_W-1:0]          w_div_den;
    logic                                 w_div_done;
    logic signed [lcadc_pkg::NET_W-1:0]   w_div_net;

    assign s_axis_tready = (r_state == T_IDLE) && (!r_m_valid || m_axis_tready);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = OUT_W'({r_net, r_raw, r_busy, r_sck});
    assign m_axis_tuser  = {r_done, r_sv};

    lcadc_seq #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (w_accept),
        .i_action  (s_axis_tuser[0]),
        .i_dout    (s_axis_tdata[0]),
        .i_cfg     (r_cfg),
        .o_flags   (w_flags),
        .o_raw     (w_raw),
        .o_div_sum (w_div_sum),
        .o_div_den (w_div_den)
    );

    lcadc_div u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_accept && w_flags.div_start),
        .i_sum    (w_div_sum),
        .i_den    (w_div_den),
        .i_offset (r_cfg.offset),
        .o_done   (w_div_done),
        .o_net    (w_div_net)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain_pulses   <= 2'd1;
            r_cfg.average_count <= lcadc_pkg::CNT_W'(1);
            r_cfg.offset        <= '0;
            r_cfg.power_down    <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                lcadc_pkg::CFG_GAIN_PULSES:   r_cfg.gain_pulses   <= i_cfg_data[1:0];
                lcadc_pkg::CFG_AVERAGE_COUNT: r_cfg.average_count <= i_cfg_data[7:0];
                lcadc_pkg::CFG_OFFSET:        r_cfg.offset        <= i_cfg_data;
                lcadc_pkg::CFG_POWER_DOWN:    r_cfg.power_down    <= i_cfg_data[0];
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= T_IDLE;
            r_m_valid <= 1'b0;
        end else begin
            case (r_state)
                T_IDLE: begin
                    if (w_accept) begin
                        if (w_flags.div_start) begin
                            r_state   <= T_DIV;
                            r_m_valid <= 1'b0;
                        end else begin
                            r_m_valid <= 1'b1;
                        end
                    end else if (m_axis_tready) begin
                        r_m_valid <= 1'b0;
                    end
                end
                T_DIV: begin
                    if (w_div_done) begin
                        r_state   <= T_IDLE;
                        r_m_valid <= 1'b1;
                    end
                end
                default: begin
                    r_state   <= T_IDLE;
                    r_m_valid <= 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_sck  <= w_flags.sck;
            r_busy <= w_flags.busy;
            r_sv   <= w_flags.sample_valid;
            r_done <= w_flags.div_start;
            r_raw  <= w_raw;
            r_net  <= '0;
        end else if ((r_state == T_DIV) && w_div_done) begin
            r_net  <= w_div_net;
        end
    end

endmodule
`default_nettype wire
